### src/rc4kc_pkg.sv
// Shared constants, types and controller-to-datapath command/status for the RC4 core.
package rc4kc_pkg;

    localparam int SBOX_DEPTH    = 256;
    localparam int SBOX_AW       = 8;
    localparam int BYTE_W        = 8;
    localparam int KEY_LEN_W     = 9;
    localparam int MAX_KEY_BYTES = 256;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(MAX_KEY_BYTES);
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MIN   = KEY_LEN_W'(1);

    localparam logic ACTION_KEY_LOAD = 1'b0;
    localparam logic ACTION_DATA     = 1'b1;

    // register index: byte address divided by four
    typedef enum logic [APB_AW-3:0] {
        REG_KEY_LEN = '0
    } cfg_reg_t;

    // S-box port operation for the current cycle
    typedef enum logic [2:0] {
        SOP_NONE,
        SOP_RD_I,
        SOP_RD_J,
        SOP_WR_I,
        SOP_WR_J,
        SOP_RD_K
    } sop_t;

    typedef struct packed {
        logic key_wr;
        logic item_load;
        logic ks_start;
        logic ks_mode;
        sop_t sop;
        logic ks_advance;
        logic idx_clear;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic ks_last;
    } dp_sts_t;

endpackage

### src/rc4_keystream_cipher_core.sv
// Top level of the RC4 keystream cipher: APB key length register, sequencer and datapath.
// Key-load beat: no result; the next beat can be taken in the following cycle.
// Data beat: no new beat is taken until its result is loaded; the steps, set by the single
//   S-box port, are read i, read j, write i, write j, read keystream, load output (held while full).
// First-of-message data beat: the key schedule runs first, each step read i, read j, write i, write j.
// Reset (aresetn low, synchronous): stream indices zero, S-box reads as identity through
//   per-entry valid bits cleared at once, key length 16; no clearing pass, key store undefined.
module rc4_keystream_cipher_core
    import rc4kc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // APB-style configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [7:0]        s_key_index,
    input  logic [7:0]        s_value,
    input  logic              s_first,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte
);

    logic [KEY_LEN_W-1:0] key_len_reg, key_len_next;
    logic                 cfg_write;
    logic [APB_AW-3:0]    reg_idx;
    dp_cmd_t              cmd;
    dp_sts_t              sts;

    // no wait states: every access completes in its access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[APB_AW-1:2];

    // decode writes; an address beyond the register list drops the beat
    always_comb begin
        key_len_next = key_len_reg;
        unique case (reg_idx)
            REG_KEY_LEN: begin
                if (cfg_write) begin
                    key_len_next = pwdata[KEY_LEN_W-1:0];
                end
            end
            default: begin
                key_len_next = key_len_reg;
            end
        endcase
    end

    // readback: the key length in the low bits, zero elsewhere
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_KEY_LEN: begin
                prdata = APB_DW'(key_len_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= KEY_LEN_RESET;
        end else begin
            key_len_reg <= key_len_next;
        end
    end

    // sequencer: one beat at a time, result parked in the output register
    rc4kc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_first  (s_first),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: S-box, key store, stream indices and output byte
    rc4kc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_key_index (s_key_index),
        .s_value     (s_value),
        .key_len     (key_len_reg),
        .out_byte    (m_out_byte)
    );

endmodule

### src/rc4kc_ctrl.sv
// Sequencer for key loads, the key schedule and one keystream step per data beat.
module rc4kc_ctrl
    import rc4kc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_action,
    input  logic    s_first,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_PG_RD_I,
        ST_PG_RD_J,
        ST_PG_WR_I,
        ST_PG_WR_J,
        ST_PG_RD_K,
        ST_PG_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   in_beat;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.sop      = SOP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_action == ACTION_KEY_LOAD) begin
                        cmd.key_wr = 1'b1;
                    end else begin
                        cmd.item_load = 1'b1;
                        if (s_first) begin
                            cmd.ks_start = 1'b1;
                            state_next   = ST_KS_RD_I;
                        end else begin
                            state_next = ST_PG_RD_I;
                        end
                    end
                end
            end
            ST_KS_RD_I: begin
                cmd.ks_mode = 1'b1;
                cmd.sop     = SOP_RD_I;
                state_next  = ST_KS_RD_J;
            end
            ST_KS_RD_J: begin
                cmd.ks_mode = 1'b1;
                cmd.sop     = SOP_RD_J;
                state_next  = ST_KS_WR_I;
            end
            ST_KS_WR_I: begin
                cmd.ks_mode = 1'b1;
                cmd.sop     = SOP_WR_I;
                state_next  = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                cmd.ks_mode    = 1'b1;
                cmd.sop        = SOP_WR_J;
                cmd.ks_advance = 1'b1;
                if (sts.ks_last) begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_PG_RD_I;
                end else begin
                    state_next = ST_KS_RD_I;
                end
            end
            ST_PG_RD_I: begin
                cmd.sop    = SOP_RD_I;
                state_next = ST_PG_RD_J;
            end
            ST_PG_RD_J: begin
                cmd.sop    = SOP_RD_J;
                state_next = ST_PG_WR_I;
            end
            ST_PG_WR_I: begin
                cmd.sop    = SOP_WR_I;
                state_next = ST_PG_WR_J;
            end
            ST_PG_WR_J: begin
                cmd.sop    = SOP_WR_J;
                state_next = ST_PG_RD_K;
            end
            ST_PG_RD_K: begin
                cmd.sop    = SOP_RD_K;
                state_next = ST_PG_OUT;
            end
            ST_PG_OUT: begin
                // hold the keystream byte until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over an undelivered beat");

    a_data_beat_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_action == ACTION_DATA) |=> !s_ready)
        else $error("input ready right after a data beat");

    a_ks_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_WR_J && !sts.ks_last) |=> state_reg == ST_KS_RD_I)
        else $error("key schedule left before its last step");

endmodule

### src/rc4kc_datapath.sv
// S-box and key store memories, stream indices and output byte register.
module rc4kc_datapath
    import rc4kc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  logic [SBOX_AW-1:0]   s_key_index,
    input  logic [BYTE_W-1:0]    s_value,
    input  logic [KEY_LEN_W-1:0] key_len,
    output logic [BYTE_W-1:0]    out_byte
);

    logic [BYTE_W-1:0]     sbox_mem [SBOX_DEPTH];
    logic [BYTE_W-1:0]     key_mem  [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] sbox_vld_reg;

    logic [SBOX_AW-1:0]    i_reg, i_next;
    logic [SBOX_AW-1:0]    j_reg, j_next;
    logic [SBOX_AW-1:0]    kpos_reg, kpos_next;
    logic [BYTE_W-1:0]     si_reg, si_next;
    logic [BYTE_W-1:0]     sj_reg, sj_next;
    logic [BYTE_W-1:0]     value_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic [BYTE_W-1:0]     mem_rdata_reg;
    logic [BYTE_W-1:0]     key_rdata_reg;
    logic                  rd_vld_reg;
    logic [SBOX_AW-1:0]    rd_addr_reg;

    logic                  rd_en, wr_en;
    logic [SBOX_AW-1:0]    rd_addr, wr_addr;
    logic [BYTE_W-1:0]     wr_data;
    logic [BYTE_W-1:0]     sbox_rdata;
    logic [SBOX_AW-1:0]    j_step;
    logic [KEY_LEN_W-1:0]  eff_len;
    logic                  kpos_wrap;

    // an entry not yet written since the last clear reads as its own index
    assign sbox_rdata = rd_vld_reg ? mem_rdata_reg : rd_addr_reg;
    assign j_step     = cmd.ks_mode ? (j_reg + sbox_rdata + key_rdata_reg)
                                    : (j_reg + sbox_rdata);

    always_comb begin
        if (key_len == '0) begin
            eff_len = KEY_LEN_MIN;
        end else if (key_len > KEY_LEN_MAX) begin
            eff_len = KEY_LEN_MAX;
        end else begin
            eff_len = key_len;
        end
    end

    assign kpos_wrap   = (KEY_LEN_W'(kpos_reg) + KEY_LEN_W'(1)) == eff_len;
    assign sts.ks_last = (i_reg == SBOX_AW'(SBOX_DEPTH - 1));

    always_comb begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_addr = i_reg;
        wr_addr = i_reg;
        wr_data = sbox_rdata;
        i_next  = i_reg;
        j_next  = j_reg;
        kpos_next = kpos_reg;
        si_next = si_reg;
        sj_next = sj_reg;
        case (cmd.sop)
            SOP_RD_I: begin
                rd_en = 1'b1;
                if (!cmd.ks_mode) begin
                    rd_addr = i_reg + SBOX_AW'(1);
                    i_next  = i_reg + SBOX_AW'(1);
                end
            end
            SOP_RD_J: begin
                rd_en   = 1'b1;
                rd_addr = j_step;
                j_next  = j_step;
                si_next = sbox_rdata;
            end
            SOP_WR_I: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = sbox_rdata;
                sj_next = sbox_rdata;
            end
            SOP_WR_J: begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = si_reg;
            end
            SOP_RD_K: begin
                rd_en   = 1'b1;
                rd_addr = si_reg + sj_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
        if (cmd.ks_advance) begin
            i_next    = i_reg + SBOX_AW'(1);
            kpos_next = kpos_wrap ? '0 : kpos_reg + SBOX_AW'(1);
        end
        if (cmd.ks_start) begin
            i_next    = '0;
            j_next    = '0;
            kpos_next = '0;
        end
        if (cmd.idx_clear) begin
            i_next = '0;
            j_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sbox_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rdata_reg <= sbox_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_wr) begin
            key_mem[s_key_index] <= s_value;
        end
        if (cmd.sop == SOP_RD_I && cmd.ks_mode) begin
            key_rdata_reg <= key_mem[kpos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.ks_start) begin
            sbox_vld_reg <= '0;
        end else if (wr_en) begin
            sbox_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg <= '0;
            j_reg <= '0;
        end else begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        kpos_reg <= kpos_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        if (rd_en) begin
            rd_vld_reg  <= sbox_vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.item_load) begin
            value_reg <= s_value;
        end
        if (cmd.out_load) begin
            out_byte_reg <= value_reg ^ sbox_rdata;
        end
    end

    assign out_byte = out_byte_reg;

    a_one_port_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("S-box read and write in the same cycle");

    a_clear_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ks_start |=> sbox_vld_reg == '0)
        else $error("S-box valid bits not cleared at schedule start");

endmodule

### verif/tb.sv
// Self-checking testbench for the RC4 keystream cipher core: key loads, data beats, key length.
`timescale 1ns / 100ps

module tb;
    import rc4kc_pkg::*;

    // Run control
    localparam int WATCHDOG_LIMIT  = 5000;  // idle cycles before the run is declared hung
    localparam int SETTLE_CYCLES   = 16;    // let a trailing key load retire before a write
    localparam int TAIL_CYCLES     = 20;    // watch for stray results once all have arrived
    localparam int ITEMS_PER_PHASE = 65;
    localparam int HOLD_AT_RESULT  = 150;   // result count at which the receiver backs off
    localparam int HOLD_CYCLES     = 400;

    localparam logic [APB_AW-1:0] KEY_LEN_ADDR = {REG_KEY_LEN, 2'b00};

    typedef struct {
        logic       action;
        logic [7:0] key_index;
        logic [7:0] value;
        logic       first;
    } cipher_beat_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic              s_action    = 1'b0;
    logic [7:0]        s_key_index = '0;
    logic [7:0]        s_value     = '0;
    logic              s_first     = 1'b0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [7:0]        m_out_byte;

    // Beats waiting to be offered, and cipher bytes owed by the block
    cipher_beat_t offered_beats[$];
    logic [7:0]   expected_bytes[$];

    // Shadow of the block: S-box, key store, stream indices and the key length register
    logic [7:0]           sbox      [SBOX_DEPTH];
    logic [7:0]           key_bytes [SBOX_DEPTH];
    logic [7:0]           si, sj;
    logic [KEY_LEN_W-1:0] key_len_reg;

    // Key store entries already loaded by the generated stimulus
    bit key_loaded [SBOX_DEPTH];

    int error_count  = 0;
    int results_seen = 0;
    int idle_cycles  = 0;

    cipher_beat_t cur_beat;
    int tx_wait = 0;
    int tx_calm = 0;
    int rx_wait = 0;
    int rx_calm = 0;

    rc4_keystream_cipher_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_key_index (s_key_index),
        .s_value     (s_value),
        .s_first     (s_first),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte)
    );

    always #5 aclk = ~aclk;

    // Key bytes the schedule cycles through: zero counts as one, saturate at the store size
    function automatic int schedule_key_bytes(logic [KEY_LEN_W-1:0] len);
        int n;
        n = len;
        if (n == 0)
            n = 1;
        if (n > MAX_KEY_BYTES)
            n = MAX_KEY_BYTES;
        return n;
    endfunction

    function automatic void run_key_schedule();
        int         n;
        logic [7:0] j;
        logic [7:0] t;
        n = schedule_key_bytes(key_len_reg);
        for (int k = 0; k < SBOX_DEPTH; k++)
            sbox[k] = 8'(k);
        j = 8'd0;
        for (int k = 0; k < SBOX_DEPTH; k++) begin
            j       = j + sbox[k] + key_bytes[k % n];
            t       = sbox[k];
            sbox[k] = sbox[j];
            sbox[j] = t;
        end
        si = 8'd0;
        sj = 8'd0;
    endfunction

    // Apply one accepted beat to the shadow; a data beat owes one cipher byte
    function automatic void predict_out_byte(cipher_beat_t b);
        logic [7:0] t;
        logic [7:0] ks_idx;
        if (b.action == ACTION_KEY_LOAD) begin
            key_bytes[b.key_index] = b.value;
            return;
        end
        if (b.first)
            run_key_schedule();
        si       = si + 8'd1;
        sj       = sj + sbox[si];
        t        = sbox[si];
        sbox[si] = sbox[sj];
        sbox[sj] = t;
        ks_idx   = sbox[si] + sbox[sj];
        expected_bytes.push_back(b.value ^ sbox[ks_idx]);
    endfunction

    // Per-beat wait: drawn at random, with occasional stretches of back-to-back beats
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic void push_beat(logic action, logic [7:0] idx, logic [7:0] val,
                                      logic first);
        cipher_beat_t b;
        b.action    = action;
        b.key_index = idx;
        b.value     = val;
        b.first     = first;
        if (action == ACTION_KEY_LOAD)
            key_loaded[idx] = 1'b1;
        offered_beats.push_back(b);
    endfunction

    function automatic bit key_covers_schedule();
        int n;
        n = schedule_key_bytes(key_len_reg);
        for (int k = 0; k < n; k++)
            if (!key_loaded[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Well-formed message: fill any key gaps, tweak a few key bytes, then first beat + body
    function automatic int queue_message(int n_data);
        int n;
        int pushed;
        int extra;
        n      = schedule_key_bytes(key_len_reg);
        pushed = 0;
        for (int k = 0; k < n; k++) begin
            if (!key_loaded[k]) begin
                push_beat(ACTION_KEY_LOAD, 8'(k), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                pushed++;
            end
        end
        extra = $urandom_range(0, (n < 8) ? n : 8);
        repeat (extra) begin
            push_beat(ACTION_KEY_LOAD, 8'($urandom_range(0, n - 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            pushed++;
        end
        push_beat(ACTION_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        for (int k = 1; k < n_data; k++)
            push_beat(ACTION_DATA, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b0);
        return pushed + n_data;
    endfunction

    // Noise: stray key loads anywhere, data without a fresh key, reschedule on the old key
    function automatic int queue_noise();
        case ($urandom_range(0, 2))
            0: begin
                push_beat(ACTION_KEY_LOAD, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            1: begin
                push_beat(ACTION_DATA, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0);
            end
            default: begin
                push_beat(ACTION_DATA, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), key_covers_schedule());
            end
        endcase
        return 1;
    endfunction

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every beat is taken and every cipher byte is back, then let the core settle
    task automatic wait_idle();
        while (offered_beats.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_key_len(input int len);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, KEY_LEN_ADDR, APB_DW'(len), rd);
        key_len_reg = KEY_LEN_W'(len);
        apb_access(1'b0, KEY_LEN_ADDR, '0, rd);
        if (rd[KEY_LEN_W-1:0] !== key_len_reg) begin
            $display("%0t: key length readback, expected %0d, got %0d",
                     $time, key_len_reg, rd[KEY_LEN_W-1:0]);
            error_count++;
        end
    endtask

    // Driver: present one beat at a time, predict it on the edge at which it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (s_valid && s_ready)
                predict_out_byte(cur_beat);
            // A held beat stays put; otherwise count down the gap or load the next beat
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    s_valid <= 1'b0;
                    tx_wait <= tx_wait - 1;
                end else if (offered_beats.size() != 0) begin
                    cur_beat    = offered_beats.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= cur_beat.action;
                    s_key_index <= cur_beat.key_index;
                    s_value     <= cur_beat.value;
                    s_first     <= cur_beat.first;
                    tx_wait     <= draw_wait(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each cipher byte against the oldest one owed, and pace m_ready
    always @(posedge aclk) begin : result_monitor
        logic [7:0] want;
        int         w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected out_byte, expected none, got %02h",
                         $time, m_out_byte);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_out_byte !== want) begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, want, m_out_byte);
                    error_count++;
                end
            end
            results_seen++;
            // Back off for a long stretch once, so the core fills up and stalls its input
            if (results_seen == HOLD_AT_RESULT) begin
                m_ready <= 1'b0;
                rx_wait <= HOLD_CYCLES;
            end else begin
                w = draw_wait(rx_calm);
                if (w > 0) begin
                    m_ready <= 1'b0;
                    rx_wait <= w - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: any beat, result or register access restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [APB_DW-1:0] rd;
        int                plan [9];
        int                count;

        // Shadow starts as the core does after reset: identity S-box, indices zero
        for (int k = 0; k < SBOX_DEPTH; k++) begin
            sbox[k]       = 8'(k);
            key_bytes[k]  = 8'd0;
            key_loaded[k] = 1'b0;
        end
        si          = 8'd0;
        sj          = 8'd0;
        key_len_reg = KEY_LEN_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_access(1'b0, KEY_LEN_ADDR, '0, rd);
        if (rd[KEY_LEN_W-1:0] !== KEY_LEN_RESET) begin
            $display("%0t: key length after reset, expected %0d, got %0d",
                     $time, KEY_LEN_RESET, rd[KEY_LEN_W-1:0]);
            error_count++;
        end

        // Directed: cipher on the identity S-box before any schedule
        push_beat(ACTION_DATA, 8'h00, 8'h00, 1'b0);
        push_beat(ACTION_DATA, 8'hFF, 8'hFF, 1'b0);
        // Key load carrying the first flag: flag dropped, no result
        push_beat(ACTION_KEY_LOAD, 8'h00, 8'hFF, 1'b1);
        push_beat(ACTION_KEY_LOAD, 8'h01, 8'h00, 1'b0);
        for (int k = 2; k < 16; k++)
            push_beat(ACTION_KEY_LOAD, 8'(k), 8'($urandom_range(0, 255)), 1'b0);
        push_beat(ACTION_KEY_LOAD, 8'hFF, 8'h00, 1'b0);
        // Schedule on the default 16-byte key, stream a few bytes, reschedule mid-stream
        push_beat(ACTION_DATA, 8'h00, 8'h00, 1'b1);
        push_beat(ACTION_DATA, 8'hFF, 8'hFF, 1'b0);
        push_beat(ACTION_DATA, 8'h3C, 8'h5A, 1'b0);
        push_beat(ACTION_DATA, 8'hC3, 8'hA5, 1'b1);

        // Key length plan: minimum, zero, full store, top of the field, reset value, random
        plan[0] = KEY_LEN_MIN;
        plan[1] = 0;
        plan[2] = KEY_LEN_MAX;
        plan[3] = (1 << KEY_LEN_W) - 1;
        plan[4] = KEY_LEN_RESET;
        plan[5] = $urandom_range(2, 15);
        plan[6] = $urandom_range(2, 255);
        plan[7] = $urandom_range(2, 255);
        plan[8] = $urandom_range(MAX_KEY_BYTES + 1, (1 << KEY_LEN_W) - 2);

        foreach (plan[p]) begin
            wait_idle();
            set_key_len(plan[p]);
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 4) != 0)
                    count += queue_message($urandom_range(1, 12));
                else
                    count += queue_noise();
            end
        end

        while (offered_beats.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
